// File: sv/ssa_pkg.sv
// Package for the scaled subvolume accumulator: store geometry, field widths,
// operation, mode and register index codes, and the one-hot state codes.
// No dependencies; used by every file in this folder but ssa_ram.
package ssa_pkg;

    // Store geometry (cubic volume, edge a power of two)
    localparam int GRID_EDGE   = 32;
    localparam int STORE_DEPTH = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int COORD_W  = 5;
    localparam int SIZE_W   = 6;
    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;
    localparam int VOXEL_W  = 32;
    localparam int TERM_W   = 27;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int SQ_W     = 2 * PROD_W;

    // Stream and configuration widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Operation codes (carried on s_tuser)
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Term modes; the unused code behaves as linear
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_LAST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_X_SIZE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y_SIZE = 3'd7;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 6'd32;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_ADDR  = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

// File: sv/ssa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/subvolume_scaled_accumulate_core.sv
// Top level of the scaled subvolume accumulator: box cursors, address and term
// arithmetic, and the read-modify-write sequencer around the volume store.
// Depends on ssa_pkg and ssa_ram.
//
//  channel  | direction | signals                       | transfers
//  ---------+-----------+-------------------------------+---------------------------
//  s_       | in        | s_tvalid s_tready s_tdata/user | one sample or read request
//  m_       | out       | m_tvalid m_tready m_tdata ...  | one voxel result per item
//  cfg_     | in        | cfg_valid cfg_ready idx/data   | one register write
//
// Each item steps in turn through accept, multiply, address and read, update and
// write back, output load; the single read-modify-write sequence bars overlap.
// After reset the store is cleared one voxel per cycle (all 32768 voxels) before
// the first item is taken; register writes are taken throughout.
// A result that is not taken holds the sequencer in its output step.
module subvolume_scaled_accumulate_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] sample, [31:16] scale, [33:32] mode, [48:34] read_address
    input  logic [ssa_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] operation
    input  logic                            s_tuser,
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] voxel_value, [46:32] voxel_address
    output logic [ssa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,    // box_done
    output logic                            m_tuser,    // [0] saturated
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssa_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import ssa_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [COORD_W-1:0] bx_first_reg, bx_last_reg, by_first_reg, by_last_reg;
    logic [COORD_W-1:0] bz_first_reg, bz_last_reg;
    logic [SIZE_W-1:0]  gx_reg, gy_reg;
    logic [2*SIZE_W-1:0] gxy_reg;

    // cursors
    logic [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [COORD_W-1:0] cx_next, cy_next, cz_next;

    // item context
    logic                     op_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic [ADDR_W-1:0]        raddr_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [SQ_W-1:0]   sq_reg;
    logic [COORD_W+2*SIZE_W-1:0] zmul_reg;
    logic [COORD_W+SIZE_W-1:0]   ymul_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic [VOXEL_W-1:0]       sum_reg;
    logic                     sat_reg;
    logic                     done_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    // combinational
    logic                      s_accept, cfg_accept, out_load, box_write;
    logic                      xend, yend, zend;
    logic [COORD_W+2*SIZE_W:0] acc_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [TERM_W-1:0]  term;
    logic [VOXEL_W-1:0]        ram_rdata;
    logic signed [VOXEL_W:0]   sum_wide;
    logic [VOXEL_W-1:0]        sum_sat;
    logic                      sum_clip;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [VOXEL_W-1:0]        ram_wdata;

    // handshakes; no item is taken in the cycle of a register write
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign s_tready   = (state_reg == ST_IDLE) & ~cfg_valid;
    assign s_accept   = s_tvalid & s_tready;
    assign out_load   = (state_reg == ST_OUT) & (~m_tvalid_reg | m_tready);
    assign box_write  = cfg_accept & (cfg_index != REG_GRID_X_SIZE)
                      & (cfg_index != REG_GRID_Y_SIZE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (&clr_cnt_reg) state_next = ST_IDLE;
            ST_IDLE:  if (s_accept) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_UPD;
            ST_UPD:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bx_first_reg <= '0;
            bx_last_reg  <= '0;
            by_first_reg <= '0;
            by_last_reg  <= '0;
            bz_first_reg <= '0;
            bz_last_reg  <= '0;
            gx_reg       <= GRID_SIZE_RESET;
            gy_reg       <= GRID_SIZE_RESET;
        end else if (cfg_accept) begin
            case (cfg_index)
                REG_BOX_X_FIRST: bx_first_reg <= cfg_data[COORD_W-1:0];
                REG_BOX_X_LAST:  bx_last_reg  <= cfg_data[COORD_W-1:0];
                REG_BOX_Y_FIRST: by_first_reg <= cfg_data[COORD_W-1:0];
                REG_BOX_Y_LAST:  by_last_reg  <= cfg_data[COORD_W-1:0];
                REG_BOX_Z_FIRST: bz_first_reg <= cfg_data[COORD_W-1:0];
                REG_BOX_Z_LAST:  bz_last_reg  <= cfg_data[COORD_W-1:0];
                REG_GRID_X_SIZE: gx_reg       <= cfg_data[SIZE_W-1:0];
                REG_GRID_Y_SIZE: gy_reg       <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // plane size, refreshed every cycle
    always_ff @(posedge aclk) begin
        gxy_reg <= gx_reg * gy_reg;
    end

    // cursor walk, z fastest; a cursor at or past its last value wraps
    assign zend = cz_reg >= bz_last_reg;
    assign yend = cy_reg >= by_last_reg;
    assign xend = cx_reg >= bx_last_reg;

    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (!zend) begin
            cz_next = cz_reg + 1'b1;
        end else begin
            cz_next = bz_first_reg;
            if (!yend) begin
                cy_next = cy_reg + 1'b1;
            end else begin
                cy_next = by_first_reg;
                cx_next = xend ? bx_first_reg : cx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
        end else if (box_write) begin
            // any box write reloads the cursors from the new first values
            cx_reg <= (cfg_index == REG_BOX_X_FIRST) ? cfg_data[COORD_W-1:0] : bx_first_reg;
            cy_reg <= (cfg_index == REG_BOX_Y_FIRST) ? cfg_data[COORD_W-1:0] : by_first_reg;
            cz_reg <= (cfg_index == REG_BOX_Z_FIRST) ? cfg_data[COORD_W-1:0] : bz_first_reg;
        end else if (out_load && op_reg == OP_ACCUM) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
    end

    // accept: latch fields, form the Q4.28 product
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= s_tuser;
            mode_reg  <= s_tdata[33:32];
            raddr_reg <= s_tdata[48:34];
            p_reg     <= $signed(s_tdata[15:0]) * $signed(s_tdata[31:16]);
        end
    end

    // multiply step: square of the product and the address partial products
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            sq_reg   <= p_reg * p_reg;
            zmul_reg <= cz_reg * gxy_reg;
            ymul_reg <= cy_reg * gx_reg;
        end
    end

    // address step: voxel address wraps to the store
    assign acc_addr = {1'b0, zmul_reg}
                    + {{(SIZE_W+1){1'b0}}, ymul_reg}
                    + {{(2*SIZE_W+1){1'b0}}, cx_reg};
    assign rd_addr  = (op_reg == OP_READ) ? raddr_reg : acc_addr[ADDR_W-1:0];

    // term rounding: floor shift plus the bit just below, ties toward +inf
    always_comb begin
        case (mode_reg)
            MODE_SQUARE: term = $signed(sq_reg[36+TERM_W-1:36])
                              + $signed({{(TERM_W-1){1'b0}}, sq_reg[35]});
            MODE_DOUBLE: term = TERM_W'($signed(p_reg[PROD_W-1:7]))
                              + $signed({{(TERM_W-1){1'b0}}, p_reg[6]});
            default:     term = TERM_W'($signed(p_reg[PROD_W-1:8]))
                              + $signed({{(TERM_W-1){1'b0}}, p_reg[7]});
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADDR) begin
            addr_reg <= rd_addr;
            term_reg <= term;
        end
    end

    // update step: add and clip to the Q11.20 range
    assign sum_wide = $signed({ram_rdata[VOXEL_W-1], ram_rdata})
                    + (VOXEL_W+1)'(term_reg);
    assign sum_clip = sum_wide[VOXEL_W] ^ sum_wide[VOXEL_W-1];
    assign sum_sat  = sum_clip ? {sum_wide[VOXEL_W], {(VOXEL_W-1){~sum_wide[VOXEL_W]}}}
                               : sum_wide[VOXEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            if (op_reg == OP_READ) begin
                sum_reg  <= ram_rdata;
                sat_reg  <= 1'b0;
                done_reg <= 1'b0;
            end else begin
                sum_reg  <= sum_sat;
                sat_reg  <= sum_clip;
                done_reg <= zend & yend & xend;
            end
        end
    end

    // store port: clearing pass or write back of the new sum
    assign ram_we    = (state_reg == ST_CLEAR) | ((state_reg == ST_UPD) & (op_reg == OP_ACCUM));
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : sum_sat;

    ssa_ram #(
        .WIDTH (VOXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_ADDR),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{(M_TDATA_W-VOXEL_W-ADDR_W){1'b0}}, addr_reg, sum_reg};
            m_tlast_reg <= done_reg;
            m_tuser_reg <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sv/ssa_checker.sv
// Port-level checker for the scaled subvolume accumulator, bound to the top level.
// Depends on ssa_pkg and subvolume_scaled_accumulate_core.
module ssa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);
    import ssa_pkg::*;

    // reset empties the output and blocks input during the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output valid or input ready right after reset");

    // an accepted item keeps the input closed for the rest of its sequence
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input reopened while an item is in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata)
                                    && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // a new result traces back to an accepted input transaction through the sequence
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
        else $error("result appeared without a matching input transaction");

endmodule

bind subvolume_scaled_accumulate_core ssa_checker u_ssa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: verif/subvolume_scaled_accumulate_core_tb.sv
// Self-checking testbench for subvolume_scaled_accumulate_core: directed table, saturation
// runs and randomized box/grid phases, checked against a voxel-store predictor and typed results.
// Depends on ssa_pkg and the core RTL.
module subvolume_scaled_accumulate_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int     IDLE_PCT        = 37;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     DRAIN_CYCLES    = 20;
    localparam int     ITEM_TARGET     = 1150;
    localparam int     RECENT_DEPTH    = 64;
    localparam int     SAT_HITS        = 16;
    localparam int     SAT_RUN_MAX     = 400;
    localparam int     READ_PCT        = 15;
    localparam int     PRINT_MAX       = 50;
    localparam longint VOXEL_MAX       = 64'sd2147483647;
    localparam longint VOXEL_MIN       = -64'sd2147483648;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample_q;
        logic [SAMPLE_W-1:0] scale_q;
        logic [MODE_W-1:0]   mode;
        logic [ADDR_W-1:0]   read_addr;
    } accum_request_t;

    typedef struct packed {
        logic [VOXEL_W-1:0] value;
        logic [ADDR_W-1:0]  addr;
        logic               done;
        logic               sat;
    } voxel_result_t;

    // one row of the directed table: a register write or a request
    typedef struct packed {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_data;
        accum_request_t       req;
        bit                   has_result;
        voxel_result_t        result;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = OP_ACCUM;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BOX_X_FIRST;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    bit no_gaps = 1'b0;
    bit hold_off_pending = 1'b0;
    int fail_count = 0;
    int items_sent = 0;

    voxel_result_t pending_voxels [$];
    voxel_result_t result_want;
    stim_row_t     directed_rows [$];

    // predictor state
    logic signed [VOXEL_W-1:0] volume_model [STORE_DEPTH];
    logic [COORD_W-1:0] cur_x, cur_y, cur_z;
    logic [COORD_W-1:0] x_first, x_last, y_first, y_last, z_first, z_last;
    logic [SIZE_W-1:0]  grid_x, grid_y;
    logic [ADDR_W-1:0]  recent_addrs [$];

    subvolume_scaled_accumulate_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void reload_cursors();
        cur_x = x_first;
        cur_y = y_first;
        cur_z = z_first;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_BOX_X_FIRST: x_first = data[COORD_W-1:0];
            REG_BOX_X_LAST:  x_last  = data[COORD_W-1:0];
            REG_BOX_Y_FIRST: y_first = data[COORD_W-1:0];
            REG_BOX_Y_LAST:  y_last  = data[COORD_W-1:0];
            REG_BOX_Z_FIRST: z_first = data[COORD_W-1:0];
            REG_BOX_Z_LAST:  z_last  = data[COORD_W-1:0];
            REG_GRID_X_SIZE: grid_x  = data[SIZE_W-1:0];
            REG_GRID_Y_SIZE: grid_y  = data[SIZE_W-1:0];
            default: ;
        endcase
        // any box register reloads the cursors, grid sizes do not
        if (idx != REG_GRID_X_SIZE && idx != REG_GRID_Y_SIZE) begin
            reload_cursors();
        end
    endfunction

    // Read-modify-write of one voxel plus the cursor walk (z fastest)
    function automatic voxel_result_t accumulate_voxel(input accum_request_t req);
        voxel_result_t     res;
        longint            prod, term, sum, flat;
        logic [ADDR_W-1:0] addr;
        logic              zend, yend, xend;
        res = '0;
        if (req.op == OP_READ) begin
            res.value = volume_model[req.read_addr];
            res.addr  = req.read_addr;
            return res;
        end
        flat = longint'(cur_z) * longint'(grid_x) * longint'(grid_y)
             + longint'(cur_y) * longint'(grid_x) + longint'(cur_x);
        addr = flat[ADDR_W-1:0];
        prod = longint'($signed(req.sample_q)) * longint'($signed(req.scale_q));
        // rounding to Q.20, ties toward plus infinity
        case (req.mode)
            MODE_SQUARE: term = (prod * prod + (64'sd1 <<< 35)) >>> 36;
            MODE_DOUBLE: term = (2 * prod + 128) >>> 8;
            default:     term = (prod + 128) >>> 8;
        endcase
        sum = longint'(volume_model[addr]) + term;
        if (sum > VOXEL_MAX) begin
            sum = VOXEL_MAX;
            res.sat = 1'b1;
        end
        if (sum < VOXEL_MIN) begin
            sum = VOXEL_MIN;
            res.sat = 1'b1;
        end
        volume_model[addr] = sum[VOXEL_W-1:0];
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > RECENT_DEPTH) begin
            void'(recent_addrs.pop_front());
        end

        zend = cur_z >= z_last;
        yend = cur_y >= y_last;
        xend = cur_x >= x_last;
        if (!zend) begin
            cur_z = cur_z + 1'b1;
        end else begin
            cur_z = z_first;
            if (!yend) begin
                cur_y = cur_y + 1'b1;
            end else begin
                cur_y = y_first;
                cur_x = xend ? x_first : cur_x + 1'b1;
            end
        end
        res.value = sum[VOXEL_W-1:0];
        res.addr  = addr;
        res.done  = zend && yend && xend;
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (fail_count < PRINT_MAX) begin
            $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
        end
        fail_count++;
    endtask

    // compare each result transaction against the oldest pending expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_voxels.size() == 0) begin
                report_mismatch("unexpected result, voxel_value",
                                longint'(m_tdata[VOXEL_W-1:0]), 64'd0);
            end else begin
                result_want = pending_voxels.pop_front();
                if (m_tdata[VOXEL_W-1:0] !== result_want.value) begin
                    report_mismatch("voxel_value", longint'(m_tdata[VOXEL_W-1:0]),
                                    longint'(result_want.value));
                end
                if (m_tdata[VOXEL_W +: ADDR_W] !== result_want.addr) begin
                    report_mismatch("voxel_address", longint'(m_tdata[VOXEL_W +: ADDR_W]),
                                    longint'(result_want.addr));
                end
                if (m_tlast !== result_want.done) begin
                    report_mismatch("box_done", longint'(m_tlast), longint'(result_want.done));
                end
                if (m_tuser !== result_want.sat) begin
                    report_mismatch("saturated", longint'(m_tuser), longint'(result_want.sat));
                end
            end
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Called at a falling edge; returns at the falling edge after the transaction,
    // leaving s_tvalid high so the next call can keep it up without a glitch.
    task automatic send_request(input accum_request_t req, input bit has_result,
                                input voxel_result_t typed_result,
                                output voxel_result_t predicted);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {{(S_TDATA_W - ADDR_W - MODE_W - 2 * SAMPLE_W){1'b0}},
                     req.read_addr, req.mode, req.scale_q, req.sample_q};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = accumulate_voxel(req);
        pending_voxels.push_back(has_result ? typed_result : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // drop valid and wait until every pending result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_voxels.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // same convention as send_request: caller lowers cfg_valid after a group
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_register(idx, data);
        @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic stim_row_t acc_row(input logic [SAMPLE_W-1:0] smp, scl,
                                          input logic [MODE_W-1:0] md);
        stim_row_t row;
        row = '0;
        row.req.op       = OP_ACCUM;
        row.req.sample_q = smp;
        row.req.scale_q  = scl;
        row.req.mode     = md;
        return row;
    endfunction

    function automatic stim_row_t read_row(input logic [ADDR_W-1:0] addr,
                                           input logic [SAMPLE_W-1:0] smp, scl,
                                           input logic [MODE_W-1:0] md);
        stim_row_t row;
        row = acc_row(smp, scl, md);
        row.req.op        = OP_READ;
        row.req.read_addr = addr;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic stim_row_t with_result(input stim_row_t row,
                                              input logic [VOXEL_W-1:0] value,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic done);
        row.has_result   = 1'b1;
        row.result.value = value;
        row.result.addr  = addr;
        row.result.done  = done;
        row.result.sat   = 1'b0;
        return row;
    endfunction

    // Q2.14 values biased toward the extremes and toward rounding ties
    function automatic logic [SAMPLE_W-1:0] random_q14();
        logic [31:0] r;
        r = $urandom;
        case (r[18:16])
            3'd0:    return 16'h8000;
            3'd1:    return 16'h7FFF;
            3'd2:    return {{7{r[8]}}, r[8:0]};
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    function automatic accum_request_t random_request();
        accum_request_t req;
        logic [31:0]    pick;
        pick = $urandom;
        req.op       = ($urandom_range(0, 99) < READ_PCT) ? OP_READ : OP_ACCUM;
        req.sample_q = random_q14();
        req.scale_q  = random_q14();
        req.mode     = pick[1:0];
        if (recent_addrs.size() != 0 && pick[2]) begin
            req.read_addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        end else begin
            pick = $urandom;
            req.read_addr = pick[ADDR_W-1:0];
        end
        return req;
    endfunction

    // one box dimension: short spans mostly, plus reversed, corner and full ranges
    task automatic pick_range(output logic [COORD_W-1:0] first, output logic [COORD_W-1:0] last);
        int f, l;
        case ($urandom_range(0, 9))
            6: begin
                f = $urandom_range(1, 31);
                l = $urandom_range(0, f - 1);
            end
            7: begin f = 0;  l = 0;  end
            8: begin f = 31; l = 31; end
            9: begin f = 0;  l = 31; end
            default: begin
                f = $urandom_range(0, 31);
                l = f + $urandom_range(0, 2);
                if (l > 31) l = 31;
            end
        endcase
        first = f[COORD_W-1:0];
        last  = l[COORD_W-1:0];
    endtask

    function automatic logic [SIZE_W-1:0] pick_grid();
        int g;
        case ($urandom_range(0, 9))
            7:       g = 32;
            8:       g = 1;
            9:       g = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
            default: g = $urandom_range(1, 32);
        endcase
        return g[SIZE_W-1:0];
    endfunction

    // random box and grid, with don't-care upper bits on the write data
    task automatic configure_phase(input bit write_all);
        logic [CFG_IDX_W-1:0] reg_ids [8];
        logic [CFG_DAT_W-1:0] vals [8];
        logic [COORD_W-1:0]   bx0, bx1, by0, by1, bz0, bz1;
        logic [31:0]          junk;
        bit                   wrote;
        reg_ids = '{REG_BOX_X_FIRST, REG_BOX_X_LAST, REG_BOX_Y_FIRST, REG_BOX_Y_LAST,
                    REG_BOX_Z_FIRST, REG_BOX_Z_LAST, REG_GRID_X_SIZE, REG_GRID_Y_SIZE};
        pick_range(bx0, bx1);
        pick_range(by0, by1);
        pick_range(bz0, bz1);
        junk = $urandom;
        vals[0] = {junk[2:0],   bx0};
        vals[1] = {junk[5:3],   bx1};
        vals[2] = {junk[8:6],   by0};
        vals[3] = {junk[11:9],  by1};
        vals[4] = {junk[14:12], bz0};
        vals[5] = {junk[17:15], bz1};
        vals[6] = {junk[19:18], pick_grid()};
        vals[7] = {junk[21:20], pick_grid()};
        wrote = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (write_all || $urandom_range(0, 99) < 60) begin
                write_register(reg_ids[i], vals[i]);
                wrote = 1'b1;
            end
        end
        if (wrote) cfg_valid <= 1'b0;
    endtask

    // box of one voxel on a 32x32 grid
    task automatic set_single_voxel(input logic [COORD_W-1:0] x, y, z);
        write_register(REG_BOX_X_FIRST, CFG_DAT_W'(x));
        write_register(REG_BOX_X_LAST,  CFG_DAT_W'(x));
        write_register(REG_BOX_Y_FIRST, CFG_DAT_W'(y));
        write_register(REG_BOX_Y_LAST,  CFG_DAT_W'(y));
        write_register(REG_BOX_Z_FIRST, CFG_DAT_W'(z));
        write_register(REG_BOX_Z_LAST,  CFG_DAT_W'(z));
        write_register(REG_GRID_X_SIZE, CFG_DAT_W'(GRID_SIZE_RESET));
        write_register(REG_GRID_Y_SIZE, CFG_DAT_W'(GRID_SIZE_RESET));
        cfg_valid <= 1'b0;
    endtask

    // hammer one voxel with full-scale terms until it clips SAT_HITS times or SAT_RUN_MAX requests have gone
    task automatic run_saturation(input bit upward);
        accum_request_t req;
        voxel_result_t  got;
        logic [31:0]    r;
        int             hits, n, scl;
        hits = 0;
        n = 0;
        while (hits < SAT_HITS && n < SAT_RUN_MAX) begin
            r = $urandom;
            req.op        = OP_ACCUM;
            req.read_addr = r[ADDR_W-1:0];
            if (upward) begin
                req.mode     = MODE_SQUARE;
                req.sample_q = r[15] ? 16'h8000 : 16'h7FFF;
                req.scale_q  = r[16] ? 16'h8000 : 16'h7FFF;
            end else begin
                scl = $urandom_range(30000, 32767);
                req.mode     = MODE_DOUBLE;
                req.sample_q = 16'h8000;
                req.scale_q  = scl[SAMPLE_W-1:0];
            end
            send_request(req, 1'b0, '0, got);
            if (got.sat) hits++;
            n++;
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        stim_row_t     row;
        voxel_result_t got;
        bit            in_writes;
        int            phase, n;

        foreach (volume_model[i]) volume_model[i] = '0;
        x_first = '0; x_last = '0;
        y_first = '0; y_last = '0;
        z_first = '0; z_last = '0;
        grid_x = GRID_SIZE_RESET;
        grid_y = GRID_SIZE_RESET;
        reload_cursors();

        // reset-state rows: box is the single voxel 0, store is clear
        directed_rows.push_back(with_result(read_row(15'h0000, 16'h0000, 16'h0000, MODE_LINEAR),
                                           32'h0000_0000, 15'h0000, 1'b0));
        directed_rows.push_back(with_result(read_row(15'h7FFF, 16'hFFFF, 16'hFFFF, MODE_UNUSED),
                                           32'h0000_0000, 15'h7FFF, 1'b0));
        // 1.0 * 1.0 is exactly 1.0 in Q11.20
        directed_rows.push_back(with_result(acc_row(16'h4000, 16'h4000, MODE_LINEAR),
                                           32'h0010_0000, 15'h0000, 1'b1));
        directed_rows.push_back(acc_row(16'h4000, 16'h4000, MODE_DOUBLE));
        directed_rows.push_back(acc_row(16'h4000, 16'h4000, MODE_SQUARE));
        directed_rows.push_back(acc_row(16'h4000, 16'h4000, MODE_UNUSED));
        directed_rows.push_back(acc_row(16'h8000, 16'h8000, MODE_SQUARE));
        directed_rows.push_back(acc_row(16'h8000, 16'h7FFF, MODE_DOUBLE));
        directed_rows.push_back(acc_row(16'h7FFF, 16'h7FFF, MODE_LINEAR));
        directed_rows.push_back(acc_row(16'h0001, 16'h0001, MODE_LINEAR));
        // exact half LSB, positive and negative ties
        directed_rows.push_back(acc_row(16'h0080, 16'h0001, MODE_LINEAR));
        directed_rows.push_back(acc_row(16'hFF80, 16'h0001, MODE_LINEAR));
        directed_rows.push_back(acc_row(16'hFFFF, 16'h0001, MODE_DOUBLE));
        directed_rows.push_back(acc_row(16'h7FFF, 16'hFFFF, MODE_SQUARE));
        // reads ignore sample, scale and mode
        directed_rows.push_back(read_row(15'h0000, 16'hFFFF, 16'hFFFF, MODE_UNUSED));
        directed_rows.push_back(read_row(15'h5555, 16'h5555, 16'hAAAA, MODE_SQUARE));
        directed_rows.push_back(read_row(15'h2AAA, 16'h0000, 16'h0000, MODE_LINEAR));
        // reversed x range, oversized grid so addresses wrap
        directed_rows.push_back(cfg_row(REG_BOX_X_FIRST, 8'd31));
        directed_rows.push_back(cfg_row(REG_BOX_X_LAST,  8'd2));
        directed_rows.push_back(cfg_row(REG_BOX_Y_FIRST, 8'd0));
        directed_rows.push_back(cfg_row(REG_BOX_Y_LAST,  8'd1));
        directed_rows.push_back(cfg_row(REG_BOX_Z_FIRST, 8'd30));
        directed_rows.push_back(cfg_row(REG_BOX_Z_LAST,  8'd31));
        directed_rows.push_back(cfg_row(REG_GRID_X_SIZE, 8'd63));
        directed_rows.push_back(cfg_row(REG_GRID_Y_SIZE, 8'd63));
        directed_rows.push_back(acc_row(16'h2000, 16'h6000, MODE_LINEAR));
        directed_rows.push_back(acc_row(16'hC000, 16'h4000, MODE_DOUBLE));
        directed_rows.push_back(acc_row(16'h7FFF, 16'h8000, MODE_SQUARE));
        directed_rows.push_back(acc_row(16'h1234, 16'hEDCB, MODE_LINEAR));
        directed_rows.push_back(acc_row(16'h4000, 16'h4000, MODE_UNUSED));
        // zero grid width: cursors keep walking, address collapses
        directed_rows.push_back(cfg_row(REG_GRID_X_SIZE, 8'd0));
        directed_rows.push_back(acc_row(16'h3000, 16'h3000, MODE_LINEAR));
        directed_rows.push_back(acc_row(16'hD000, 16'h3000, MODE_DOUBLE));
        // box write in mid-walk sends the cursors back to the first corner
        directed_rows.push_back(cfg_row(REG_BOX_Z_LAST, 8'd31));
        directed_rows.push_back(acc_row(16'h0100, 16'h0100, MODE_SQUARE));
        directed_rows.push_back(read_row(15'd31, 16'h0000, 16'h0000, MODE_LINEAR));

        // reset, then release at a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        in_writes = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_write) begin
                if (!in_writes) drain_results();
                write_register(row.reg_idx, row.reg_data);
                in_writes = 1'b1;
            end else begin
                if (in_writes) cfg_valid <= 1'b0;
                in_writes = 1'b0;
                send_request(row.req, row.has_result, row.result, got);
            end
        end

        // clip toward the negative limit, then toward the positive one
        drain_results();
        set_single_voxel(5'd31, 5'd31, 5'd31);
        run_saturation(1'b0);
        drain_results();
        set_single_voxel(5'd30, 5'd31, 5'd31);
        run_saturation(1'b1);

        // random phases, each with its own box and grid
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain_results();
            configure_phase(phase == 0);
            no_gaps = (phase == 2 || phase == 5);
            if (phase == 5) hold_off_pending = 1'b1;
            n = (phase == 5) ? 80 : $urandom_range(15, 60);
            repeat (n) send_request(random_request(), 1'b0, '0, got);
            phase++;
        end
        no_gaps = 1'b0;

        // let the pipeline empty out
        s_tvalid <= 1'b0;
        while (pending_voxels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog: covers the post-reset store clear with a wide margin
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/subvolume_scaled_accumulate_core.sv
sv/ssa_checker.sv
verif/subvolume_scaled_accumulate_core_tb.sv
